// ===== src/matrix_inverse_3x3_defines.svh =====
// assertion macros for the 3x3 matrix inverse block
`ifndef MATRIX_INVERSE_3X3_DEFINES_SVH
`define MATRIX_INVERSE_3X3_DEFINES_SVH

`ifndef SYNTHESIS
`define MI3_ASSERT_IMP(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");
`define MI3_ASSERT_NXT(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define MI3_ASSERT_IMP(label, clk, rstn, ante, cons)
`define MI3_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif

`endif

// ===== src/mi3_pkg.sv =====
// shared constants for the 3x3 matrix inverse block
package mi3_pkg;
	localparam int unsigned NUM_ELEM = 9;
	localparam int unsigned NUM_PIV = 3;

	// cofactor k = e[a]*e[b] - e[c]*e[d]
	localparam int unsigned COF_IDX [NUM_ELEM][4] = '{
		'{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
		'{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
		'{3, 7, 4, 6}, '{6, 1, 0, 7}, '{0, 4, 1, 3}
	};
endpackage

// ===== src/matrix_inverse_3x3.sv =====
// throughput: one matrix per cycle while the output is not stalled; the restoring
// divider is unrolled into one pipeline stage per quotient bit, nine lanes wide
// a stalled output holds the whole pipeline; arst_n clears all valid bits,
// payload registers keep whatever they held
`include "matrix_inverse_3x3_defines.svh"

module matrix_inverse_3x3 #(
	parameter int ELEM_WIDTH = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [ELEM_WIDTH-1:0] elem_0,
	input  logic signed [ELEM_WIDTH-1:0] elem_1,
	input  logic signed [ELEM_WIDTH-1:0] elem_2,
	input  logic signed [ELEM_WIDTH-1:0] elem_3,
	input  logic signed [ELEM_WIDTH-1:0] elem_4,
	input  logic signed [ELEM_WIDTH-1:0] elem_5,
	input  logic signed [ELEM_WIDTH-1:0] elem_6,
	input  logic signed [ELEM_WIDTH-1:0] elem_7,
	input  logic signed [ELEM_WIDTH-1:0] elem_8,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [ELEM_WIDTH-1:0] inv_0,
	output logic signed [ELEM_WIDTH-1:0] inv_1,
	output logic signed [ELEM_WIDTH-1:0] inv_2,
	output logic signed [ELEM_WIDTH-1:0] inv_3,
	output logic signed [ELEM_WIDTH-1:0] inv_4,
	output logic signed [ELEM_WIDTH-1:0] inv_5,
	output logic signed [ELEM_WIDTH-1:0] inv_6,
	output logic signed [ELEM_WIDTH-1:0] inv_7,
	output logic signed [ELEM_WIDTH-1:0] inv_8,
	output logic                         singular,
	output logic                         saturated
);
	import mi3_pkg::*;

	localparam int W = ELEM_WIDTH;
	localparam int CW = 2 * W + 1;
	localparam int TW = 3 * W + 1;
	localparam int DW = 3 * W + 3;
	localparam int NW = CW + 2 * FRAC_BITS;
	localparam int XW = DW + W;
	localparam int NS = W + 7;

	logic en;
	logic [NS-1:0] vld_q;

	logic signed [W-1:0] e_in [NUM_ELEM];

	logic signed [2*W-1:0] prod_a_s1 [NUM_ELEM];
	logic signed [2*W-1:0] prod_b_s1 [NUM_ELEM];
	logic signed [W-1:0] piv_s1 [NUM_PIV];
	logic signed [CW-1:0] cof_s2 [NUM_ELEM];
	logic signed [W-1:0] piv_s2 [NUM_PIV];
	logic signed [2*W+1:0] plo_s3 [NUM_PIV];
	logic signed [2*W-1:0] phi_s3 [NUM_PIV];
	logic signed [CW-1:0] cof_s3 [NUM_ELEM];
	logic signed [TW-1:0] term_s4 [NUM_PIV];
	logic signed [CW-1:0] cof_s4 [NUM_ELEM];
	logic signed [DW-1:0] det_s5;
	logic signed [CW-1:0] cof_s5 [NUM_ELEM];
	logic [CW-1:0] cmag_s6 [NUM_ELEM];
	logic [DW-1:0] dmag_s6;
	logic [NUM_ELEM-1:0] neg_s6;
	logic sing_s6;

	// divider stages, one quotient bit each
	logic [NW-1:0] rem_sd [W][NUM_ELEM];
	logic [W-1:0] quo_sd [W][NUM_ELEM];
	logic [DW-1:0] dmag_sd [W];
	logic [NUM_ELEM-1:0] neg_sd [W];
	logic [NUM_ELEM-1:0] big_sd [W];
	logic sing_sd [W];

	logic signed [W-1:0] inv_s7 [NUM_ELEM];
	logic sing_s7;
	logic sat_s7;

	logic [W-1:0] fin_val [NUM_ELEM];
	logic [NUM_ELEM-1:0] fin_over;

	assign e_in[0] = elem_0;
	assign e_in[1] = elem_1;
	assign e_in[2] = elem_2;
	assign e_in[3] = elem_3;
	assign e_in[4] = elem_4;
	assign e_in[5] = elem_5;
	assign e_in[6] = elem_6;
	assign e_in[7] = elem_7;
	assign e_in[8] = elem_8;

	assign en = !vld_q[NS-1] || !out_stall;
	assign in_stall = !en;
	assign out_valid = vld_q[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NS-2:0], in_valid};
		end
	end

	for (genvar k = 0; k < NUM_ELEM; k++) begin : g_lane
		always_ff @(posedge clk) begin
			if (en) begin
				prod_a_s1[k] <= e_in[COF_IDX[k][0]] * e_in[COF_IDX[k][1]];
				prod_b_s1[k] <= e_in[COF_IDX[k][2]] * e_in[COF_IDX[k][3]];
				cof_s2[k] <= CW'(prod_a_s1[k]) - CW'(prod_b_s1[k]);
				cof_s3[k] <= cof_s2[k];
				cof_s4[k] <= cof_s3[k];
				cof_s5[k] <= cof_s4[k];
				cmag_s6[k] <= cof_s5[k][CW-1] ? CW'(-cof_s5[k]) : CW'(cof_s5[k]);
				neg_s6[k] <= cof_s5[k][CW-1] ^ det_s5[DW-1];
			end
		end
	end

	for (genvar p = 0; p < NUM_PIV; p++) begin : g_piv
		// expansion runs down column 0: elements 0, 3 and 6
		always_ff @(posedge clk) begin
			if (en) begin
				piv_s1[p] <= e_in[3*p];
				piv_s2[p] <= piv_s1[p];
				// cofactor split into an unsigned low half and a signed high half
				plo_s3[p] <= piv_s2[p] * $signed({1'b0, cof_s2[p][W:0]});
				phi_s3[p] <= piv_s2[p] * $signed(cof_s2[p][CW-1:W+1]);
				term_s4[p] <= (TW'(phi_s3[p]) <<< (W + 1)) + TW'(plo_s3[p]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			det_s5 <= DW'(term_s4[0]) + DW'(term_s4[1]) + DW'(term_s4[2]);
			dmag_s6 <= det_s5[DW-1] ? DW'(-det_s5) : DW'(det_s5);
			sing_s6 <= det_s5 == '0;
		end
	end

	for (genvar t = 0; t < W; t++) begin : g_div
		localparam int J = W - 1 - t;
		logic [NW-1:0] r_in [NUM_ELEM];
		logic [W-1:0] q_in [NUM_ELEM];
		logic [DW-1:0] d_in;
		logic [NUM_ELEM-1:0] n_in;
		logic [NUM_ELEM-1:0] b_in;
		logic s_in;
		logic [XW-1:0] sub;

		if (t == 0) begin : g_first
			logic [XW-1:0] lim_cmp;
			assign lim_cmp = XW'(dmag_s6) << W;
			for (genvar k = 0; k < NUM_ELEM; k++) begin : g_ld
				assign r_in[k] = {cmag_s6[k], {(2*FRAC_BITS){1'b0}}};
				assign q_in[k] = '0;
				// quotient of 2^W or more can never fit
				assign b_in[k] = XW'(r_in[k]) >= lim_cmp;
			end
			assign d_in = dmag_s6;
			assign n_in = neg_s6;
			assign s_in = sing_s6;
		end else begin : g_next
			assign r_in = rem_sd[t-1];
			assign q_in = quo_sd[t-1];
			assign d_in = dmag_sd[t-1];
			assign n_in = neg_sd[t-1];
			assign b_in = big_sd[t-1];
			assign s_in = sing_sd[t-1];
		end

		assign sub = XW'(d_in) << J;

		for (genvar k = 0; k < NUM_ELEM; k++) begin : g_step
			logic ge;
			assign ge = XW'(r_in[k]) >= sub;
			always_ff @(posedge clk) begin
				if (en) begin
					rem_sd[t][k] <= ge ? NW'(XW'(r_in[k]) - sub) : r_in[k];
					quo_sd[t][k] <= {q_in[k][W-2:0], ge};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dmag_sd[t] <= d_in;
				neg_sd[t] <= n_in;
				big_sd[t] <= b_in;
				sing_sd[t] <= s_in;
			end
		end
	end

	always_comb begin
		for (int k = 0; k < NUM_ELEM; k++) begin
			logic [W-1:0] lim;
			logic [W-1:0] v;
			lim = neg_sd[W-1][k] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
			fin_over[k] = big_sd[W-1][k] || (quo_sd[W-1][k] > lim);
			v = fin_over[k] ? lim : quo_sd[W-1][k];
			fin_val[k] = neg_sd[W-1][k] ? W'(-v) : v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NUM_ELEM; k++) begin
				inv_s7[k] <= sing_sd[W-1] ? '0 : $signed(fin_val[k]);
			end
			sing_s7 <= sing_sd[W-1];
			sat_s7 <= !sing_sd[W-1] && (|fin_over);
		end
	end

	assign inv_0 = inv_s7[0];
	assign inv_1 = inv_s7[1];
	assign inv_2 = inv_s7[2];
	assign inv_3 = inv_s7[3];
	assign inv_4 = inv_s7[4];
	assign inv_5 = inv_s7[5];
	assign inv_6 = inv_s7[6];
	assign inv_7 = inv_s7[7];
	assign inv_8 = inv_s7[8];
	assign singular = sing_s7;
	assign saturated = sat_s7;

	`MI3_ASSERT_IMP(a_sing_no_sat, clk, arst_n, out_valid && singular, !saturated)
	`MI3_ASSERT_IMP(a_sing_zero, clk, arst_n, out_valid && singular, (inv_0 | inv_4 | inv_8) == '0)
	`MI3_ASSERT_IMP(a_stall_only_full, clk, arst_n, in_stall, out_valid && out_stall)
	`MI3_ASSERT_NXT(a_no_drop, clk, arst_n, vld_q[NS-2] && en, out_valid)
endmodule
